// ----- hdl/srl_pkg.sv -----
`default_nettype none
package srl_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int SCORE_W  = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_BACK   = 3'd1,
    OP_PUSH_SORTED = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_BACK    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP_FRONT,
    S_POP_BACK
  } state_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_REPORT,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_SCAN_PLACE,
    CMD_POP_FRONT_RD,
    CMD_POP_BACK_RD,
    CMD_POP_FRONT_DONE,
    CMD_POP_BACK_DONE
  } dp_cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [SCORE_W-1:0]      score;
  } rec_t;

  typedef struct packed {
    dp_cmd_t op;
    status_t status;
  } dp_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_less;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/srl_ifs.sv -----
`default_nettype none
interface srl_in_if import srl_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [KEY_W-1:0] record_key;
  logic [SCORE_W-1:0]      record_score;

  modport source (output valid, opcode, record_key, record_score, input ready);
  modport sink (input valid, opcode, record_key, record_score, output ready);
endinterface

interface srl_out_if import srl_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_W-1:0]      entry_count;
  logic signed [KEY_W-1:0] removed_key;
  logic [SCORE_W-1:0]      removed_score;

  modport source (output valid, status, entry_count, removed_key, removed_score,
                  input ready);
  modport sink (input valid, status, entry_count, removed_key, removed_score,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/srl_ctrl.sv -----
`default_nettype none
module srl_ctrl import srl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  input  logic [OP_W-1:0] opcode,
  output logic            ready,
  input  dp_stat_t        stat,
  output dp_ctl_t         ctl
);

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = CMD_IDLE;
    ctl.status = ST_DONE;
    ready      = !rst && (state == S_IDLE) && stat.out_free;
    accept     = valid && ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_PUSH_FRONT: begin
              if (stat.full) begin
                ctl.op     = CMD_REPORT;
                ctl.status = ST_FULL;
              end else begin
                ctl.op = CMD_PUSH_FRONT;
              end
            end
            OP_PUSH_BACK: begin
              if (stat.full) begin
                ctl.op     = CMD_REPORT;
                ctl.status = ST_FULL;
              end else begin
                ctl.op = CMD_PUSH_BACK;
              end
            end
            OP_PUSH_SORTED: begin
              if (stat.full) begin
                ctl.op     = CMD_REPORT;
                ctl.status = ST_FULL;
              end else begin
                ctl.op     = CMD_SCAN_START;
                state_next = S_SCAN;
              end
            end
            OP_POP_FRONT: begin
              if (stat.empty) begin
                ctl.op     = CMD_REPORT;
                ctl.status = ST_EMPTY;
              end else begin
                ctl.op     = CMD_POP_FRONT_RD;
                state_next = S_POP_FRONT;
              end
            end
            OP_POP_BACK: begin
              if (stat.empty) begin
                ctl.op     = CMD_REPORT;
                ctl.status = ST_EMPTY;
              end else begin
                ctl.op     = CMD_POP_BACK_RD;
                state_next = S_POP_BACK;
              end
            end
            default: begin
              ctl.op = CMD_REPORT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (stat.scan_less) begin
          ctl.op = CMD_SCAN_STEP;
        end else begin
          ctl.op     = CMD_SCAN_PLACE;
          state_next = S_IDLE;
        end
      end
      S_POP_FRONT: begin
        ctl.op     = CMD_POP_FRONT_DONE;
        state_next = S_IDLE;
      end
      S_POP_BACK: begin
        ctl.op     = CMD_POP_BACK_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/srl_dp.sv -----
`default_nettype none
module srl_dp import srl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [KEY_W-1:0] record_key,
  input  logic [SCORE_W-1:0]      record_score,
  input  dp_ctl_t                 ctl,
  output dp_stat_t                stat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [COUNT_W-1:0]      out_count,
  output logic signed [KEY_W-1:0] out_key,
  output logic [SCORE_W-1:0]      out_score
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
    idx_inc = (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
    idx_dec = (a == '0) ? AW'(CAPACITY - 1) : a - 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    idx_add = s[AW-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] c);
    logic [CW+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, c};
    to_count = ext[COUNT_W-1:0];
  endfunction

  rec_t mem [CAPACITY];
  rec_t rdata;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] scan_rd, scan_rd_next;
  logic [AW-1:0] scan_wr, scan_wr_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  rec_t          item, item_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;
  logic [AW-1:0] rd_addr;

  logic                    load;
  logic [STATUS_W-1:0]     load_status;
  logic [CW-1:0]           load_count;
  rec_t                    load_rec;

  assign cnt_m1 = count - CW'(1);

  assign stat.full      = (count == CW'(CAPACITY));
  assign stat.empty     = (count == '0);
  assign stat.scan_less = (scan_idx < count) && ($signed(rdata.key) < $signed(item.key));
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    head_next     = head;
    count_next    = count;
    scan_rd_next  = scan_rd;
    scan_wr_next  = scan_wr;
    scan_idx_next = scan_idx;
    item_next     = item;
    wr_en         = 1'b0;
    wr_addr       = head;
    wr_data       = '{key: record_key, score: record_score};
    rd_addr       = head;
    load          = 1'b0;
    load_status   = ST_DONE;
    load_count    = count;
    load_rec      = '0;
    case (ctl.op)
      CMD_REPORT: begin
        load        = 1'b1;
        load_status = ctl.status;
      end
      CMD_PUSH_FRONT: begin
        wr_en      = 1'b1;
        wr_addr    = idx_dec(head);
        head_next  = idx_dec(head);
        count_next = count + 1'b1;
        load       = 1'b1;
        load_count = count_next;
      end
      CMD_PUSH_BACK: begin
        wr_en      = 1'b1;
        wr_addr    = idx_add(head, count[AW-1:0]);
        count_next = count + 1'b1;
        load       = 1'b1;
        load_count = count_next;
      end
      CMD_SCAN_START: begin
        rd_addr       = head;
        scan_rd_next  = idx_inc(head);
        scan_wr_next  = idx_dec(head);
        scan_idx_next = '0;
        item_next     = '{key: record_key, score: record_score};
      end
      CMD_SCAN_STEP: begin
        wr_en         = 1'b1;
        wr_addr       = scan_wr;
        wr_data       = rdata;
        rd_addr       = scan_rd;
        scan_rd_next  = idx_inc(scan_rd);
        scan_wr_next  = idx_inc(scan_wr);
        scan_idx_next = scan_idx + 1'b1;
      end
      CMD_SCAN_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = scan_wr;
        wr_data    = item;
        head_next  = idx_dec(head);
        count_next = count + 1'b1;
        load       = 1'b1;
        load_count = count_next;
      end
      CMD_POP_FRONT_RD: begin
        rd_addr = head;
      end
      CMD_POP_BACK_RD: begin
        rd_addr = idx_add(head, cnt_m1[AW-1:0]);
      end
      CMD_POP_FRONT_DONE: begin
        head_next  = idx_inc(head);
        count_next = cnt_m1;
        load       = 1'b1;
        load_count = cnt_m1;
        load_rec   = rdata;
      end
      CMD_POP_BACK_DONE: begin
        count_next = cnt_m1;
        load       = 1'b1;
        load_count = cnt_m1;
        load_rec   = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_rd  <= scan_rd_next;
    scan_wr  <= scan_wr_next;
    scan_idx <= scan_idx_next;
    item     <= item_next;
    if (load) begin
      out_status <= load_status;
      out_count  <= to_count(load_count);
      out_key    <= load_rec.key;
      out_score  <= load_rec.score;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sorted_record_list_core.sv -----
// push front, push back, refused and unused operations: result registered in the cycle after the beat
// pop front and pop back: one record memory read, then result loaded in S_POP_FRONT or S_POP_BACK
// sorted insert: controller walks the records ahead of the new one in S_SCAN, then places it and
//   loads the result; one record walked per cycle through the memory read port
// one beat in flight; the next beat is taken once the result register is free or drained
// rst clears count, head pointer, controller state and result valid; memory is not cleared
`default_nettype none
module sorted_record_list_core import srl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  srl_in_if.sink    item,
  srl_out_if.source result
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  srl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .valid  (item.valid),
    .opcode (item.opcode),
    .ready  (item.ready),
    .stat   (stat),
    .ctl    (ctl)
  );

  srl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .record_key   (item.record_key),
    .record_score (item.record_score),
    .ctl          (ctl),
    .stat         (stat),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_status   (result.status),
    .out_count    (result.entry_count),
    .out_key      (result.removed_key),
    .out_score    (result.removed_score)
  );

endmodule
`default_nettype wire
